FILE: hw/rtl/psc_pkg.sv
// Package for the protected symbol checker: constants, shared types and the CRC byte update.
package psc_pkg;

  // Symbol layout: two length bytes, then four CRC bytes, then the packet.
  localparam logic [15:0] HEADER_BYTES = 16'd6;
  localparam logic [15:0] LENGTH_BYTES = 16'd2;
  localparam int          BYTE_BITS    = 8;

  // Reflected CRC-32.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam logic REG_SYMBOL_LENGTH     = 1'b0;
  localparam logic REG_MAX_PACKET_LENGTH = 1'b1;

  // Configuration reset values.
  localparam logic [15:0] SYMBOL_LENGTH_RESET     = 16'd1024;
  localparam logic [15:0] MAX_PACKET_LENGTH_RESET = 16'd1018;

  // Configuration seen by the frame logic.
  typedef struct packed {
    logic [15:0] symbol_length;
    logic [15:0] max_packet_length;
  } cfg_t;

  // Outcome of processing one byte.
  typedef struct packed {
    logic        last;
    logic        ok;
    logic [15:0] length;
  } result_t;

  // One byte of the reflected CRC-32, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < BYTE_BITS; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/psc_frame.sv
// Per-symbol state of the checker: header capture, running CRC and the end-of-symbol verdict.
module psc_frame import psc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  byte_in,
  input  cfg_t        cfg,
  output result_t     result
);

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] header_length, header_length_next;
  logic [31:0] expected_crc, expected_crc_next;
  logic [31:0] running_crc, running_crc_next;

  logic [15:0] slen;
  logic [15:0] last_pos;
  logic [15:0] crc_offset;
  logic [15:0] pkt_offset;
  logic [15:0] hl_upd;
  logic [31:0] exp_upd;
  logic [31:0] crc_upd;
  logic        is_last;

  // A symbol length of zero acts as one.
  assign slen     = (cfg.symbol_length == 16'd0) ? 16'd1 : cfg.symbol_length;
  assign last_pos = slen - 16'd1;
  assign is_last  = (byte_position >= last_pos);

  assign crc_offset = byte_position - LENGTH_BYTES;
  assign pkt_offset = byte_position - HEADER_BYTES;

  // Fold the current byte into the header fields or the CRC.
  always_comb begin
    hl_upd  = header_length;
    exp_upd = expected_crc;
    crc_upd = running_crc;
    if (byte_position < LENGTH_BYTES) begin
      hl_upd = header_length | ({8'd0, byte_in} << {byte_position[0], 3'b000});
    end else if (byte_position < HEADER_BYTES) begin
      exp_upd = expected_crc | ({24'd0, byte_in} << {crc_offset[1:0], 3'b000});
    end else if (pkt_offset < header_length) begin
      crc_upd = crc_byte(running_crc, byte_in);
    end
  end

  // Verdict on the last byte, using the updated header and CRC.
  always_comb begin
    result.last   = is_last;
    result.ok     = 1'b0;
    result.length = 16'd0;
    if (slen >= HEADER_BYTES) begin
      result.ok = (hl_upd <= cfg.max_packet_length) &&
                  (hl_upd <= (slen - HEADER_BYTES)) &&
                  ((crc_upd ^ CRC_ONES) == exp_upd);
      result.length = hl_upd;
    end
  end

  // Next state: advance the position, or clear for the next symbol.
  always_comb begin
    byte_position_next = byte_position;
    header_length_next = header_length;
    expected_crc_next  = expected_crc;
    running_crc_next   = running_crc;
    if (advance) begin
      if (is_last) begin
        byte_position_next = 16'd0;
        header_length_next = 16'd0;
        expected_crc_next  = 32'd0;
        running_crc_next   = CRC_ONES;
      end else begin
        byte_position_next = byte_position + 16'd1;
        header_length_next = hl_upd;
        expected_crc_next  = exp_upd;
        running_crc_next   = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 16'd0;
      header_length <= 16'd0;
      expected_crc  <= 32'd0;
      running_crc   <= CRC_ONES;
    end else begin
      byte_position <= byte_position_next;
      header_length <= header_length_next;
      expected_crc  <= expected_crc_next;
      running_crc   <= running_crc_next;
    end
  end

  // The state is fresh after the last byte of a symbol.
  assert property (@(posedge clk) disable iff (rst)
    advance && result.last |=> byte_position == 16'd0 && running_crc == CRC_ONES)
    else $error("symbol state not cleared after last byte");

  // A byte that does not end the symbol moves the position by one.
  assert property (@(posedge clk) disable iff (rst)
    advance && !result.last |=> byte_position == $past(byte_position) + 16'd1)
    else $error("byte position did not step by one");

  // Without a byte to process the state holds.
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(byte_position) && $stable(running_crc))
    else $error("symbol state changed without a byte");

endmodule

FILE: hw/rtl/protected_symbol_checker.sv
// Top level of the protected symbol checker: configuration, input stage and result register.
// Bytes of each fixed-size symbol enter one per cycle; one item is taken every clock as long as
// the result side keeps up. A byte is held in the input register, then the combinational CRC byte
// update and header capture fold it into the registered per-symbol state. On the last byte of a
// symbol a result (symbol_ok, packet_length) is loaded into the output register. Only the last
// byte of a symbol can stall when a previous result has not been taken; other bytes always flow.
module protected_symbol_checker import psc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  sym_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        symbol_ok,
  output logic [15:0] packet_length,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  result_t     result;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_free;
  logic        advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.symbol_length     <= SYMBOL_LENGTH_RESET;
      cfg.max_packet_length <= MAX_PACKET_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYMBOL_LENGTH:     cfg.symbol_length     <= cfg_data;
        REG_MAX_PACKET_LENGTH: cfg.max_packet_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // The staged byte moves on unless it ends a symbol and the result slot is full.
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && (!result.last || out_free);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= sym_byte;
    end
  end

  psc_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (s1_byte),
    .cfg     (cfg),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.last) begin
      symbol_ok     <= result.ok;
      packet_length <= result.length;
    end
  end

  // A staged byte that cannot move on stays in the input register.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_byte))
    else $error("staged byte lost while stalled");

  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    advance && result.last |-> out_free)
    else $error("result overwritten");

endmodule
